// File: rtl/core/spob_pkg.sv
// Shared types and constants for the servo PWM output bank.
package spob_pkg;

  // Fixed field widths
  localparam int MODE_W     = 2;
  localparam int CHAN_W     = 4;
  localparam int PULSE_W    = 16;
  localparam int PERIOD_W   = 15;
  localparam int PINS       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Channel count and tick rate
  localparam int CHANNELS_DEF = 8;
  localparam int TICK_HZ      = 1000000;
  localparam int RATE_MIN_HZ  = 50;

  // Period at reset: slowest servo rate
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(TICK_HZ / RATE_MIN_HZ - 1);

  // Request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_SET  = 2'd1,
    MODE_GET  = 2'd2
  } mode_t;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_PERIOD = 2'd0;
  localparam cfg_idx_t REG_ARMED  = 2'd1;
  localparam cfg_idx_t REG_MASK   = 2'd2;

  // Request payload
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAN_W-1:0]  channel;
    logic [PULSE_W-1:0] pulse_value;
  } cmd_t;

  // Result payload
  typedef struct packed {
    logic [PINS-1:0]    pin_levels;
    logic [PULSE_W-1:0] read_value;
    logic               status;
  } rsp_t;

  // Decoded request strobes handed to the counter and channel bank
  typedef struct packed {
    logic               tick;
    logic               set;
    logic               get;
    logic [CHAN_W-1:0]  channel;
    logic [PULSE_W-1:0] pulse_value;
  } step_t;

endpackage

// File: rtl/core/spob_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface spob_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/spob_counter.sv
// Shared tick counter with period and arm registers.
module spob_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  spob_pkg::cfg_idx_t            cfg_index,
  input  logic [spob_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          tick,
  output logic [spob_pkg::PERIOD_W-1:0] count_after
);
  import spob_pkg::*;

  logic [PERIOD_W-1:0] period;
  logic                armed;
  logic [PERIOD_W-1:0] count;

  // Count after this request: wrap once at or past the period
  always_comb begin
    count_after = count;
    if (tick && armed) begin
      if (count >= period) begin
        count_after = '0;
      end else begin
        count_after = count + PERIOD_W'(1);
      end
    end
  end

  // Period write also restarts the counter
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      armed  <= 1'b0;
      count  <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_PERIOD) begin
        period <= cfg_data[PERIOD_W-1:0];
        count  <= '0;
      end else begin
        count <= count_after;
      end
      if (cfg_we && cfg_index == REG_ARMED) begin
        armed <= cfg_data[0];
      end
    end
  end

  // Counter never runs past the period
  a_count_in_period: assert property (@(posedge clk) disable iff (rst)
    count <= period)
    else $error("tick counter beyond period");

  // Disarmed counter holds unless the period is rewritten
  a_frozen_when_disarmed: assert property (@(posedge clk) disable iff (rst)
    !armed && !cfg_we |=> $stable(count))
    else $error("counter moved while disarmed");

endmodule

// File: rtl/core/spob_channel_bank.sv
// Per-channel compare registers, pin compare and set/get access.
module spob_channel_bank #(
  parameter int CHANNELS = spob_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spob_pkg::step_t               step,
  input  logic [spob_pkg::PERIOD_W-1:0] count_after,
  input  logic [spob_pkg::PINS-1:0]     mask,
  output spob_pkg::rsp_t                result
);
  import spob_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [PULSE_W-1:0] cmp       [CHANNELS];
  logic [PULSE_W-1:0] cmp_after [CHANNELS];
  logic [IDX_W-1:0]   idx;
  logic               chan_ok;
  logic               wr;
  logic [PULSE_W-1:0] wdata;
  logic [PINS-1:0]    pins;

  // Address decode
  assign idx     = step.channel[IDX_W-1:0];
  assign chan_ok = {1'b0, step.channel} < (CHAN_W + 1)'(CHANNELS);
  assign wr      = step.set && chan_ok;
  assign wdata   = (step.pulse_value == '0) ? '0 : step.pulse_value - PULSE_W'(1);

  // Compare values after this request
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      cmp_after[i] = (wr && idx == IDX_W'(i)) ? wdata : cmp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cmp[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        cmp[i] <= cmp_after[i];
      end
    end
  end

  // Pin levels from updated counter and compares
  for (genvar g = 0; g < PINS; g++) begin : g_pin
    if (g < CHANNELS) begin : g_live
      assign pins[g] = mask[g] && ({1'b0, count_after} < cmp_after[g]);
    end else begin : g_none
      assign pins[g] = 1'b0;
    end
  end

  // Result fields
  always_comb begin
    result.pin_levels = pins;
    result.read_value = (step.get && chan_ok) ? cmp[idx] : '0;
    result.status     = (step.set || step.get) && !chan_ok;
  end

  // A bad channel never returns data
  a_bad_chan_zero: assert property (@(posedge clk) disable iff (rst)
    result.status |-> result.read_value == '0)
    else $error("read data on out-of-range channel");

  // Ticks never report status
  a_tick_no_status: assert property (@(posedge clk) disable iff (rst)
    step.tick |-> !result.status && !wr)
    else $error("tick request touched channel access");

endmodule

// File: rtl/core/servo_pwm_output_bank_core.sv
// Servo PWM output bank: request register, decode, result register.
// A request is held in the request register, then in the result register.
// Throughput: one request per cycle unless rsp stalls; the counter step and all pin
// compares sit between the request register and the result register.
// Reset (rst, synchronous): period 19999, disarmed, mask 0, counter 0,
// all compare values 0, both pipeline registers empty.
module servo_pwm_output_bank_core #(
  parameter int CHANNELS = spob_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  spob_stream_if.sink                     cmd,
  spob_stream_if.source                   rsp,
  input  logic                            cfg_we,
  input  spob_pkg::cfg_idx_t              cfg_index,
  input  logic [spob_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spob_pkg::*;

  logic                s1_valid;
  cmd_t                s1;
  logic                advance;
  step_t               step;
  logic [PERIOD_W-1:0] count_after;
  logic [PINS-1:0]     mask;
  rsp_t                result;
  logic                o_valid;
  rsp_t                o_data;

  // Pipeline handshake
  assign advance   = s1_valid && (!o_valid || rsp.ready);
  assign cmd.ready = !s1_valid || advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1 <= cmd.payload;
    end
  end

  // Decode the held request; strobes only when it moves on
  always_comb begin
    step.tick        = 1'b0;
    step.set         = 1'b0;
    step.get         = 1'b0;
    step.channel     = s1.channel;
    step.pulse_value = s1.pulse_value;
    case (s1.mode)
      MODE_TICK: step.tick = advance;
      MODE_SET:  step.set  = advance;
      MODE_GET:  step.get  = advance;
      default:   ;
    endcase
  end

  // Channel mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_we && cfg_index == REG_MASK) begin
      mask <= cfg_data[PINS-1:0];
    end
  end

  spob_counter u_counter (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .tick        (step.tick),
    .count_after (count_after)
  );

  spob_channel_bank #(
    .CHANNELS (CHANNELS)
  ) u_bank (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .count_after (count_after),
    .mask        (mask),
    .result      (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= advance || (o_valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_data <= result;
    end
  end

  assign rsp.valid   = o_valid;
  assign rsp.payload = o_data;

  // A request that moves on always lands in the result register
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> o_valid)
    else $error("advanced request lost");

  // Empty request register always takes a new request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> cmd.ready)
    else $error("request register empty but not ready");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    o_valid && !rsp.ready |-> !advance)
    else $error("result overwritten while stalled");

endmodule
